// ----- rtl/core/bpa_pkg.sv -----
// Shared command, status and field-width constants for the buddy page allocator.
package bpa_pkg;

  localparam int CMD_W    = 2;
  localparam int SIZE_W   = 23;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int BASE_W   = 20;
  localparam int FSP_W    = 11;
  localparam int FPC_W    = 11;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_COUNT = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;

endpackage

// ----- rtl/core/bpa_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
module bpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/buddy_page_allocator_unit.sv -----
// Buddy page allocator: one free bit per block and order, held in one RAM.
// Reset and init both sweep the map to zero. Init then frees the range one block
// insert at a time; each insert climbs one order while the buddy it reads is free.
// Alloc scans the map one bit a cycle from the wanted order upward, then splits;
// free inserts maximal aligned blocks.
// One item at a time; busy is high while at work; one result strobe per item.
module buddy_page_allocator_unit import bpa_pkg::*; #(
  parameter int POOL_PAGES = 1024,
  parameter int NUM_ORDERS = 11,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [SIZE_W-1:0]     in_size_bytes,
  input  logic [ADDR_W-1:0]     in_address,
  output logic                  out_valid,
  output logic [ADDR_W-1:0]     out_block_address,
  output logic [STATUS_W-1:0]   out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TOP       = NUM_ORDERS - 1;
  localparam int MAP_DEPTH = 2 * POOL_PAGES - 1;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int PW        = $clog2(POOL_PAGES) + 1;
  localparam int OW        = $clog2(NUM_ORDERS + 1);
  localparam int WW        = ADDR_W + 2;
  localparam int PG_W      = SIZE_W + 1;
  localparam logic [AW:0]   TWO_P   = (AW+1)'(2 * POOL_PAGES);
  localparam logic [PW-1:0] POOL_PW = PW'(POOL_PAGES);
  localparam logic [OW-1:0] TOP_O   = OW'(TOP);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_RANGE  = 4'd3;
  localparam logic [3:0] S_INS_RD = 4'd4;
  localparam logic [3:0] S_INS_CK = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_TAKE   = 4'd7;
  localparam logic [3:0] S_SPLIT  = 4'd8;

  function automatic logic [AW-1:0] midx(input logic [OW-1:0] o, input logic [PW-1:0] b);
    logic [AW:0] s;
    s = TWO_P - (TWO_P >> o) + (AW+1)'(b);
    return s[AW-1:0];
  endfunction

  // config registers
  logic [BASE_W-1:0] base_r;
  logic [FSP_W-1:0]  fsp_r;
  logic [FPC_W-1:0]  fpc_r;

  logic [3:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              init_pend_r, init_pend_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PW-1:0]     rs_r, rs_nxt, re_r, re_nxt;
  logic [OW-1:0]     io_r, io_nxt;
  logic [PW-1:0]     ib_r, ib_nxt;
  logic              ret_split_r, ret_split_nxt;
  logic [OW-1:0]     so_r, so_nxt, po_r, po_nxt;
  logic [PW-1:0]     sb_r, sb_nxt, pb_r, pb_nxt;
  logic [AW-1:0]     sa_r, sa_nxt;
  logic              pv_r, pv_nxt;
  logic [OW-1:0]     want_r, want_nxt, fo_r, fo_nxt;
  logic [PW-1:0]     page_r, page_nxt;
  logic              ov_r, ov_nxt;
  logic [ADDR_W-1:0] oa_r, oa_nxt;
  status_t           os_r, os_nxt;

  logic          we, wdata, rdata;
  logic [AW-1:0] waddr, raddr;

  bpa_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // request decode terms
  logic [PG_W-1:0] pages;
  logic [WW-1:0]   pabs, diff;
  logic [OW-1:0]   want_c;
  logic [PW-1:0]   span, az, fl;
  logic [OW-1:0]   ord_c;
  logic [17:0]     is_s, is_e;
  logic [ADDR_W-1:0] sum32;

  always_comb begin
    pages = PG_W'((PG_W'(size_r) + PG_W'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT);
    pabs  = WW'(addr_r >> PAGE_SHIFT);
    diff  = pabs - WW'(base_r);
    want_c = '0;
    for (int k = 0; k < NUM_ORDERS; k++) begin
      if (PG_W'(pages) > (PG_W'(1) << k)) want_c = OW'(k + 1);
    end
    span = re_r - rs_r;
    az = PW'(TOP);
    for (int k = PW - 1; k >= 0; k--) begin
      if (rs_r[k]) az = PW'(k);
    end
    if (az > PW'(TOP)) az = PW'(TOP);
    fl = '0;
    for (int k = 0; k < PW; k++) begin
      if (span[k]) fl = PW'(k);
    end
    if (fl > PW'(TOP)) fl = PW'(TOP);
    ord_c = (fl < az) ? OW'(fl) : OW'(az);
    is_s = (18'(fsp_r) > 18'(POOL_PAGES)) ? 18'(POOL_PAGES) : 18'(fsp_r);
    is_e = is_s + 18'(fpc_r);
    if (is_e > 18'(POOL_PAGES)) is_e = 18'(POOL_PAGES);
    sum32 = ADDR_W'(base_r) + ADDR_W'(page_r);
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    init_pend_nxt = init_pend_r;
    rs_nxt = rs_r;
    re_nxt = re_r;
    io_nxt = io_r;
    ib_nxt = ib_r;
    ret_split_nxt = ret_split_r;
    so_nxt = so_r;
    sb_nxt = sb_r;
    sa_nxt = sa_r;
    pv_nxt = 1'b0;
    po_nxt = so_r;
    pb_nxt = sb_r;
    want_nxt = want_r;
    fo_nxt = fo_r;
    page_nxt = page_r;
    ov_nxt = 1'b0;
    oa_nxt = oa_r;
    os_nxt = os_r;
    we = 1'b0;
    waddr = clr_r;
    wdata = 1'b0;
    raddr = sa_r;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MAP_DEPTH - 1)) begin
          clr_nxt = '0;
          state_nxt = init_pend_r ? S_RANGE : S_IDLE;
          init_pend_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) state_nxt = S_DEC;
      end
      S_DEC: begin
        oa_nxt = '0;
        os_nxt = ST_OK;
        priority if (cmd_r == CMD_INIT) begin
          rs_nxt = PW'(is_s);
          re_nxt = PW'(is_e);
          init_pend_nxt = 1'b1;
          state_nxt = S_CLEAR;
        end else if (cmd_r == CMD_ALLOC) begin
          if (pages == '0 || pages > (PG_W'(1) << TOP)) begin
            os_nxt = ST_BAD;
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            want_nxt = want_c;
            so_nxt = want_c;
            sb_nxt = '0;
            sa_nxt = midx(want_c, '0);
            state_nxt = S_SCAN;
          end
        end else if (cmd_r == CMD_FREE) begin
          if (addr_r[PAGE_SHIFT-1:0] != '0) begin
            os_nxt = ST_BAD;
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (pages == '0) begin
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (pabs < WW'(base_r) || diff + WW'(pages) > WW'(POOL_PAGES)) begin
            os_nxt = ST_BAD;
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            rs_nxt = diff[PW-1:0];
            re_nxt = diff[PW-1:0] + PW'(pages);
            state_nxt = S_RANGE;
          end
        end else begin
          os_nxt = ST_BAD;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RANGE: begin
        if (rs_r < re_r) begin
          io_nxt = ord_c;
          ib_nxt = rs_r >> ord_c;
          rs_nxt = rs_r + (PW'(1) << ord_c);
          ret_split_nxt = 1'b0;
          state_nxt = S_INS_RD;
        end else begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS_RD: begin
        if (io_r < TOP_O) begin
          raddr = midx(io_r, ib_r ^ PW'(1));
          state_nxt = S_INS_CK;
        end else begin
          we = 1'b1;
          waddr = midx(io_r, ib_r);
          wdata = 1'b1;
          state_nxt = ret_split_r ? S_SPLIT : S_RANGE;
        end
      end
      S_INS_CK: begin
        we = 1'b1;
        if (rdata) begin
          // buddy free: take it and climb one order
          waddr = midx(io_r, ib_r ^ PW'(1));
          wdata = 1'b0;
          ib_nxt = ib_r >> 1;
          io_nxt = io_r + 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          waddr = midx(io_r, ib_r);
          wdata = 1'b1;
          state_nxt = ret_split_r ? S_SPLIT : S_RANGE;
        end
      end
      S_SCAN: begin
        // read issued this cycle returns next cycle with po/pb
        if (pv_r && rdata) begin
          fo_nxt = po_r;
          page_nxt = pb_r << po_r;
          state_nxt = S_TAKE;
        end else if (so_r > TOP_O) begin
          if (!pv_r) begin
            os_nxt = ST_OOM;
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          raddr = sa_r;
          pv_nxt = 1'b1;
          sa_nxt = sa_r + 1'b1;
          if (sb_r == (POOL_PW >> so_r) - PW'(1)) begin
            sb_nxt = '0;
            so_nxt = so_r + 1'b1;
          end else begin
            sb_nxt = sb_r + 1'b1;
          end
        end
      end
      S_TAKE: begin
        we = 1'b1;
        waddr = midx(fo_r, page_r >> fo_r);
        wdata = 1'b0;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (fo_r > want_r) begin
          fo_nxt = fo_r - 1'b1;
          io_nxt = fo_r - 1'b1;
          ib_nxt = (page_r >> (fo_r - 1'b1)) + PW'(1);
          ret_split_nxt = 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          oa_nxt = sum32 << PAGE_SHIFT;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      init_pend_r <= 1'b0;
      pv_r <= 1'b0;
      ov_r <= 1'b0;
      base_r <= '0;
      fsp_r <= '0;
      fpc_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      init_pend_r <= init_pend_nxt;
      pv_r <= pv_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_POOL_BASE:  base_r <= cfg_data[BASE_W-1:0];
          REG_FREE_START: fsp_r <= cfg_data[FSP_W-1:0];
          REG_FREE_COUNT: fpc_r <= cfg_data[FPC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_cmd;
      size_r <= in_size_bytes;
      addr_r <= in_address;
    end
    rs_r <= rs_nxt;
    re_r <= re_nxt;
    io_r <= io_nxt;
    ib_r <= ib_nxt;
    ret_split_r <= ret_split_nxt;
    so_r <= so_nxt;
    sb_r <= sb_nxt;
    sa_r <= sa_nxt;
    po_r <= po_nxt;
    pb_r <= pb_nxt;
    want_r <= want_nxt;
    fo_r <= fo_nxt;
    page_r <= page_nxt;
    oa_r <= oa_nxt;
    os_r <= os_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_block_address = oa_r;
  assign out_status = os_r;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the buddy page allocator unit.
`timescale 1ns / 1ps

module testbench;
  import bpa_pkg::*;

  localparam int POOL_PAGES = 1024;
  localparam int NUM_ORDERS = 11;
  localparam int PAGE_SHIFT = 12;
  localparam int TOP_ORDER = NUM_ORDERS - 1;
  localparam int MAP_DEPTH = 2 * POOL_PAGES - 1;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
  localparam int STALL_LIMIT = 40000;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [ADDR_W-1:0] block_address;
    status_t status;
  } alloc_result_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    int unsigned bytes;
  } held_block_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [CMD_W-1:0] in_cmd;
  logic [SIZE_W-1:0] in_size_bytes;
  logic [ADDR_W-1:0] in_address;
  logic out_valid;
  logic [ADDR_W-1:0] out_block_address;
  logic [STATUS_W-1:0] out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  buddy_page_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_size_bytes(in_size_bytes), .in_address(in_address),
    .out_valid(out_valid), .out_block_address(out_block_address),
    .out_status(out_status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow allocator state
  bit free_bits [MAP_DEPTH];
  logic [19:0] pool_base;
  logic [10:0] free_start;
  logic [10:0] free_count;

  alloc_result_t pending_results[$];
  held_block_t held[$];
  int errors = 0;
  int burst_left = 0;
  bit start_hi = 0;
  bit steady = 0;
  int stall_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int map_slot(int ord, int blk);
    return 2 * POOL_PAGES - 2 * (POOL_PAGES >> ord) + blk;
  endfunction

  function automatic bit is_free(int ord, int blk);
    int i;
    i = map_slot(ord, blk);
    return (i < MAP_DEPTH) ? free_bits[i] : 1'b0;
  endfunction

  function automatic void mark(int ord, int blk, bit v);
    int i;
    i = map_slot(ord, blk);
    if (i < MAP_DEPTH) free_bits[i] = v;
  endfunction

  function automatic void release_block(int page, int ord);
    int blk;
    blk = page >> ord;
    while (ord < TOP_ORDER && is_free(ord, blk ^ 1)) begin
      mark(ord, blk ^ 1, 0);
      blk = blk >> 1;
      ord++;
    end
    mark(ord, blk, 1);
  endfunction

  function automatic void release_span(int first, int last);
    int ord;
    int fit;
    while (first < last) begin
      ord = 0;
      if (first == 0) ord = TOP_ORDER;
      else while (ord < TOP_ORDER && ((first >> ord) & 1) == 0) ord++;
      fit = 0;
      while (fit < TOP_ORDER && ((last - first) >> (fit + 1)) != 0) fit++;
      if (fit < ord) ord = fit;
      release_block(first, ord);
      first += 1 << ord;
    end
  endfunction

  function automatic alloc_result_t model_command(logic [CMD_W-1:0] cmd,
                                                   logic [SIZE_W-1:0] size,
                                                   logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    longint unsigned pages;
    longint unsigned page_abs;
    int first;
    int last;
    int want;
    int ord;
    int found;
    int page;
    bit hit;
    r.block_address = '0;
    r.status = ST_OK;
    pages = (longint'(size) + PAGE_BYTES - 1) >> PAGE_SHIFT;
    if (cmd == CMD_INIT) begin
      foreach (free_bits[i]) free_bits[i] = 0;
      first = (int'(free_start) > POOL_PAGES) ? POOL_PAGES : int'(free_start);
      last = first + int'(free_count);
      if (last > POOL_PAGES) last = POOL_PAGES;
      release_span(first, last);
    end else if (cmd == CMD_ALLOC) begin
      if (pages == 0 || pages > (1 << TOP_ORDER)) begin
        r.status = ST_BAD;
      end else begin
        want = 0;
        while ((longint'(1) << want) < pages) want++;
        hit = 0;
        found = 0;
        for (ord = want; ord <= TOP_ORDER && !hit; ord++) begin
          for (int b = 0; b < (POOL_PAGES >> ord); b++) begin
            if (is_free(ord, b)) begin
              found = b;
              hit = 1;
              break;
            end
          end
          if (hit) break;
        end
        if (!hit) begin
          r.status = ST_OOM;
        end else begin
          page = found << ord;
          mark(ord, found, 0);
          while (ord > want) begin
            ord--;
            release_block(page + (1 << ord), ord);
          end
          r.block_address = ADDR_W'((longint'(pool_base) + page) << PAGE_SHIFT);
        end
      end
    end else if (cmd == CMD_FREE) begin
      page_abs = addr >> PAGE_SHIFT;
      if (addr[PAGE_SHIFT-1:0] != 0) begin
        r.status = ST_BAD;
      end else if (pages != 0) begin
        if (page_abs < pool_base || page_abs - pool_base + pages > POOL_PAGES) begin
          r.status = ST_BAD;
        end else begin
          first = int'(page_abs - pool_base);
          release_span(first, first + int'(pages));
        end
      end
    end else begin
      r.status = ST_BAD;
    end
    return r;
  endfunction

  // results are checked as they come; the block cannot be held off
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: block_address %h status %0d",
               out_block_address, out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_block_address !== e.block_address) begin
          $error("block_address expected %h actual %h", e.block_address, out_block_address);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                      logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    int gap;
    held_block_t h;
    in_cmd <= cmd;
    in_size_bytes <= size;
    in_address <= addr;
    start <= 1'b1;
    start_hi = 1;
    do @(posedge clk); while (busy);
    r = model_command(cmd, size, addr);
    pending_results.push_back(r);
    if (cmd == CMD_INIT) held.delete();
    if (cmd == CMD_ALLOC && r.status == ST_OK) begin
      h.addr = r.block_address;
      h.bytes = 32'(size);
      held.push_back(h);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if (gap > 0 && !steady) begin
        start <= 1'b0;
        start_hi = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_POOL_BASE: pool_base = data;
      REG_FREE_START: free_start = data[10:0];
      REG_FREE_COUNT: free_count = data[10:0];
      default: ;
    endcase
  endtask

  task automatic setup_pool(int base, int first, int count);
    drain();
    write_reg(REG_POOL_BASE, CFG_DATA_W'(base));
    write_reg(REG_FREE_START, CFG_DATA_W'(first));
    write_reg(REG_FREE_COUNT, CFG_DATA_W'(count));
  endtask

  task automatic test_empty_pool();
    send(CMD_ALLOC, SIZE_W'(PAGE_BYTES), '0);
    send(CMD_ALLOC, '0, '0);
    send(CMD_ALLOC, 23'h7FFFFF, '0);
    send(CMD_FREE, SIZE_W'(PAGE_BYTES), 32'h0000_0001);
    send(CMD_UNKNOWN, '0, '0);
    send(CMD_INIT, '0, '0);
    send(CMD_ALLOC, SIZE_W'(1), '0);
  endtask

  task automatic test_full_pool();
    setup_pool(0, 0, 1024);
    send(CMD_INIT, 23'h7FFFFF, 32'hFFFF_FFFF);
    send(CMD_ALLOC, SIZE_W'(POOL_PAGES * PAGE_BYTES), '0);
    send(CMD_ALLOC, SIZE_W'(1), '0);
    send(CMD_FREE, SIZE_W'(POOL_PAGES * PAGE_BYTES), '0);
    send(CMD_ALLOC, SIZE_W'(POOL_PAGES * PAGE_BYTES + 1), '0);
    send(CMD_ALLOC, SIZE_W'(3 * PAGE_BYTES), '0);
    send(CMD_ALLOC, SIZE_W'(PAGE_BYTES), '0);
    send(CMD_FREE, SIZE_W'(PAGE_BYTES), 32'h0000_4000);
    // same page again: stays free, no error
    send(CMD_FREE, SIZE_W'(PAGE_BYTES), 32'h0000_4000);
    send(CMD_FREE, '0, 32'h0000_1000);
    send(CMD_FREE, SIZE_W'(2 * PAGE_BYTES), 32'h003F_F000);
    send(CMD_FREE, SIZE_W'(PAGE_BYTES), 32'h0040_0000);
    send(CMD_ALLOC, SIZE_W'(2 * PAGE_BYTES), '0);
  endtask

  task automatic test_clipped_init();
    setup_pool(20'hFFFFF, 2047, 2047);
    send(CMD_INIT, '0, '0);
    send(CMD_ALLOC, SIZE_W'(PAGE_BYTES), '0);
    setup_pool(20'h00400, 1000, 2047);
    send(CMD_INIT, '0, '0);
    send(CMD_ALLOC, SIZE_W'(8 * PAGE_BYTES), '0);
    send(CMD_FREE, SIZE_W'(PAGE_BYTES), 32'h003F_F000);
  endtask

  task automatic random_phase(int n, int base, int first, int count);
    int sel;
    int idx;
    int unsigned pg;
    logic [SIZE_W-1:0] sz;
    held_block_t h;
    setup_pool(base, first, count);
    steady = ($urandom_range(0, 3) == 0);
    send(CMD_INIT, SIZE_W'($urandom), $urandom);
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 9))
          0: sz = SIZE_W'($urandom_range(1, POOL_PAGES * PAGE_BYTES));
          1: sz = SIZE_W'($urandom);
          default: sz = SIZE_W'($urandom_range(1, 16 * PAGE_BYTES));
        endcase
        send(CMD_ALLOC, sz, $urandom);
      end else if (sel < 85 && held.size() != 0) begin
        idx = $urandom_range(0, held.size() - 1);
        h = held[idx];
        held.delete(idx);
        sz = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, h.bytes))
                                          : SIZE_W'(h.bytes);
        send(CMD_FREE, sz, h.addr);
      end else if (sel < 92) begin
        pg = $urandom_range(0, POOL_PAGES - 1);
        sz = SIZE_W'($urandom_range(0, (POOL_PAGES - pg) * PAGE_BYTES + PAGE_BYTES));
        send(CMD_FREE, sz, ADDR_W'((pool_base + pg) << PAGE_SHIFT));
      end else if (sel < 97) begin
        send(CMD_FREE, SIZE_W'($urandom), $urandom);
      end else if (sel < 99) begin
        send(CMD_UNKNOWN, SIZE_W'($urandom), $urandom);
      end else begin
        send(CMD_INIT, SIZE_W'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_random();
    random_phase(165, 0, 0, 1024);
    random_phase(165, 20'hFFC00, 0, 1024);
    random_phase(110, 20'hFFFFF, 3, 1000);
    random_phase(165, 0, 0, 0);
    random_phase(165, $urandom_range(0, 1023) << 10, $urandom_range(0, 1024),
                 $urandom_range(0, 1024));
    random_phase(165, $urandom_range(0, 1023) << 10, $urandom_range(0, 64), 1024);
    random_phase(165, $urandom_range(0, 1023) << 10, $urandom_range(0, 1024),
                 $urandom_range(0, 1024));
    random_phase(165, 20'h12345, 2047, 2047);
    random_phase(165, $urandom_range(0, 1023) << 10, 1, 1023);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_INIT;
    in_size_bytes <= '0;
    in_address <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_POOL_BASE;
    cfg_data <= '0;
    foreach (free_bits[i]) free_bits[i] = 0;
    pool_base = 0;
    free_start = 0;
    free_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pool();
    test_full_pool();
    test_clipped_init();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/buddy_page_allocator_unit.sv
tb/testbench.sv
